>>> rtl/core/sizep_pkg.sv
// Shared types and constants for the memory size text parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sizep_pkg;

   localparam int CHAR_W = 8;
   localparam int SIZE_W = 31;

   localparam logic [SIZE_W-1:0] VALUE_MAX   = {SIZE_W{1'b1}};
   localparam logic [SIZE_W-1:0] LIMIT_RESET = SIZE_W'(1024 * 1024 * 1024);

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_K     = 8'h4B;
   localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

   typedef enum logic [2:0] {
      PH_NUMBER = 3'b001,
      PH_TRAIL  = 3'b010,
      PH_FAILED = 3'b100
   } phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              is_last;
      logic              no_character;
   } item_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size_bytes;
      logic              size_ok;
   } result_type;

   function automatic logic is_white(input logic [CHAR_W-1:0] c);
      is_white = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

endpackage

>>> rtl/core/memory_size_text_parser.sv
// Channel  | direction | contents
// req_     | in        | tdata: character, tlast: is_last, tuser: no_character
// rsp_     | out       | tdata: size_bytes, tuser: size_ok (one per string)
// csr_     | in        | size_limit write
//
// One character per cycle sustained while no last character waits on a response; a
// character goes input register -> parse step -> response register, so a response
// is registered from the parse step of its last character.
// The parse state updates in the same cycle as the step, which sets the rate.
// Reset clears the parse state and sets size_limit to 1 GiB.
// A waiting response stalls only a last character; others keep flowing.
// Top level of the size parser; depends on sizep_pkg, sizep_in_reg, sizep_parse.
`timescale 1ns / 1ps

module memory_size_text_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] character
   input  logic                          req_tlast,   // is_last
   input  logic                          req_tuser,   // no_character
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // [30:0] size_bytes, [31] zero
   output logic                          rsp_tuser,   // size_ok
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sizep_pkg::SIZE_W-1:0]  csr_data    // size_limit
);
   import sizep_pkg::*;

   item_type          req_item;
   item_type          hold_item;
   logic              hold_valid;
   logic              hold_take;
   logic              out_free;
   result_type        step_result;

   logic [SIZE_W-1:0] limit_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   assign req_item.character    = req_tdata;
   assign req_item.is_last      = req_tlast;
   assign req_item.no_character = req_tuser;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign hold_take = hold_valid && (!hold_item.is_last || out_free);

   sizep_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .hold_valid (hold_valid),
      .hold_take  (hold_take),
      .hold_item  (hold_item)
   );

   sizep_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (hold_take),
      .item       (hold_item),
      .size_limit (limit_ff),
      .result     (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (hold_take && hold_item.is_last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.size_bytes};
   assign rsp_tuser  = rsp_data_ff.size_ok;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(hold_take && hold_item.is_last && !out_free))
      else $error("response overwritten before it was taken");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.size_ok) |-> (rsp_data_ff.size_bytes == '0))
      else $error("failed parse carries a nonzero size");

   a_ok_within_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.size_ok) |-> (rsp_data_ff.size_bytes <= limit_ff))
      else $error("accepted size above limit");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (hold_take && hold_item.is_last) |=> rsp_valid_ff)
      else $error("last character gave no response");

endmodule

>>> rtl/core/sizep_in_reg.sv
// Input register stage for the size parser: holds one request transaction.
// Depends on sizep_pkg.
`timescale 1ns / 1ps

module sizep_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sizep_pkg::item_type in_item,
   output logic                hold_valid,
   input  logic                hold_take,
   output sizep_pkg::item_type hold_item
);
   import sizep_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready = !valid_ff || hold_take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

>>> rtl/core/sizep_parse.sv
// Per-character parse step and parse state (phase, value, digit and overflow flags).
// Depends on sizep_pkg.
`timescale 1ns / 1ps

module sizep_parse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  sizep_pkg::item_type               item,
   input  logic [sizep_pkg::SIZE_W-1:0]      size_limit,
   output sizep_pkg::result_type             result
);
   import sizep_pkg::*;

   phase_type         phase_ff, phase_in, phase_nx;
   logic [SIZE_W-1:0] acc_ff, acc_in, acc_nx;
   logic              seen_ff, seen_in, seen_nx;
   logic              ovf_ff, ovf_in, ovf_nx;

   logic [SIZE_W+3:0]  acc_x;
   logic [SIZE_W+3:0]  mul10;
   logic [CHAR_W-1:0]  c;
   logic               ok;

   assign c     = item.character;
   assign acc_x = {4'b0, acc_ff};
   assign mul10 = (acc_x << 3) + (acc_x << 1) + {{(SIZE_W+4-4){1'b0}}, c[3:0]};

   // state after this character, before the end-of-string clear
   always_comb begin
      phase_nx = phase_ff;
      acc_nx   = acc_ff;
      seen_nx  = seen_ff;
      ovf_nx   = ovf_ff;
      if (!item.no_character) begin
         case (phase_ff)
            PH_NUMBER: begin
               if (c >= CH_ZERO && c <= CH_NINE) begin
                  seen_nx = 1'b1;
                  if (mul10[SIZE_W+3:SIZE_W] != 4'b0) begin
                     ovf_nx = 1'b1;
                     acc_nx = VALUE_MAX;
                  end else begin
                     acc_nx = mul10[SIZE_W-1:0];
                  end
               end else if (is_white(c)) begin
                  phase_nx = PH_NUMBER;
               end else if (c == CH_K) begin
                  phase_nx = PH_TRAIL;
                  if (acc_ff[SIZE_W-1:SIZE_W-10] != 10'b0) begin
                     ovf_nx = 1'b1;
                     acc_nx = VALUE_MAX;
                  end else begin
                     acc_nx = {acc_ff[SIZE_W-11:0], 10'b0};
                  end
               end else if (c == CH_M) begin
                  phase_nx = PH_TRAIL;
                  if (acc_ff[SIZE_W-1:SIZE_W-20] != 20'b0) begin
                     ovf_nx = 1'b1;
                     acc_nx = VALUE_MAX;
                  end else begin
                     acc_nx = {acc_ff[SIZE_W-21:0], 20'b0};
                  end
               end else begin
                  phase_nx = PH_FAILED;
               end
            end
            PH_TRAIL: begin
               if (!is_white(c)) begin
                  phase_nx = PH_FAILED;
               end
            end
            default: begin
               phase_nx = PH_FAILED;
            end
         endcase
      end
   end

   always_comb begin
      phase_in = phase_nx;
      acc_in   = acc_nx;
      seen_in  = seen_nx;
      ovf_in   = ovf_nx;
      if (item.is_last) begin
         phase_in = PH_NUMBER;
         acc_in   = '0;
         seen_in  = 1'b0;
         ovf_in   = 1'b0;
      end
   end

   always_comb begin
      ok = 1'b0;
      case (phase_nx)
         PH_NUMBER, PH_TRAIL: ok = 1'b1;
         default:             ok = 1'b0;
      endcase
      ok = ok && seen_nx && !ovf_nx && (acc_nx <= size_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NUMBER;
         acc_ff   <= '0;
         seen_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign result.size_ok    = ok;
   assign result.size_bytes = ok ? acc_nx : '0;

endmodule
